// ===== hw/rtl/rsp_pkg.sv =====
// Package for the road scanline pixel generator: sizes, codes and shared types.
// No dependencies; the interfaces, the block and the testbench import it.
`timescale 1ns / 1ps

package rsp_pkg;

  // Road graphics store geometry
  localparam int GRAPHICS_ROWS    = 256;
  localparam int GRAPHICS_COLUMNS = 512;
  localparam int GFX_DEPTH        = GRAPHICS_ROWS * GRAPHICS_COLUMNS;
  localparam int GFX_ADDR_W       = (GFX_DEPTH > 1) ? $clog2(GFX_DEPTH) : 1;
  localparam int GFX_W            = 2;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 9;
  localparam int CTRL_W    = 12;
  localparam int SCROLL_W  = 12;
  localparam int BGC_W     = 16;
  localparam int PIXC_W    = 8;
  localparam int COLOR_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Pixel value that selects the background fill
  localparam logic [GFX_W-1:0] MD_BACKGROUND = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_LINE  = 2'd1,
    FUNC_PIXEL = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROAD_VARIANT = 2'd0,
    REG_PIXEL_BASE   = 2'd1,
    REG_BG_BASE      = 2'd2
  } cfg_reg_e;

endpackage

// ===== hw/rtl/rsp_in_if.sv =====
// Input channel of the road scanline pixel generator: valid/ready plus item fields.
// Depends on rsp_pkg for field widths.
`timescale 1ns / 1ps

interface rsp_in_if;
  import rsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ROW_W-1:0]    graphics_row;
  logic [COL_W-1:0]    graphics_column;
  logic [GFX_W-1:0]    graphics_value;
  logic [CTRL_W-1:0]   line_control;
  logic [SCROLL_W-1:0] line_scroll;
  logic [BGC_W-1:0]    line_background_colors;
  logic [PIXC_W-1:0]   line_pixel_colors;

  modport source (
    output valid, func, graphics_row, graphics_column, graphics_value,
           line_control, line_scroll, line_background_colors, line_pixel_colors,
    input  ready
  );

  modport sink (
    input  valid, func, graphics_row, graphics_column, graphics_value,
           line_control, line_scroll, line_background_colors, line_pixel_colors,
    output ready
  );

endinterface

// ===== hw/rtl/rsp_out_if.sv =====
// Output channel of the road scanline pixel generator: valid/ready plus pixel fields.
// Depends on rsp_pkg for field widths.
`timescale 1ns / 1ps

interface rsp_out_if;
  import rsp_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic               is_foreground_line;

  modport source (
    output valid, pixel_color, is_foreground_line,
    input  ready
  );

  modport sink (
    input  valid, pixel_color, is_foreground_line,
    output ready
  );

endinterface

// ===== hw/rtl/road_scanline_pixel_generator.sv =====
// Road scanline pixel generator: road graphics store, per-line counters and color output.
// Depends on rsp_pkg, rsp_in_if, rsp_out_if and rsp_ram.
// Pipeline: the RAM read and stage 1 load at the edge that accepts a pixel item; its
//   color then passes into the output register.
// Throughput: one item per cycle; the single RAM port serves one load write or one
//   pixel read per cycle, which sets that figure. Input stalls only while both stage 1
//   and the output register hold pixels that the receiver has not taken.
// Reset: rst_ni resets the line state and clears the config registers and valid flags;
//   the graphics store is not cleared and holds nothing defined until loaded.
`timescale 1ns / 1ps

module road_scanline_pixel_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rsp_in_if.sink                        in_i,
  rsp_out_if.source                     out_o
);
  import rsp_pkg::*;

  // What a pixel item carries from the RAM read cycle into the color cycle.
  typedef struct packed {
    logic              bg_fill;     // background flag seen by this pixel
    logic              md_read;     // pixel value comes from the RAM
    logic              select;      // delay shifter bit 3
    logic [5:0]        bg_color;    // background color already picked by select
    logic [PIXC_W-1:0] pix_colors;
    logic              fg;
  } s1_t;

  // Configuration
  logic               variant_q;
  logic [COLOR_W-1:0] pix_base_q;
  logic [COLOR_W-1:0] bg_base_q;

  // Line state
  logic [CTRL_W-1:0] ctrl_q;
  logic [BGC_W-1:0]  bgc_q;
  logic [PIXC_W-1:0] pixc_q;
  logic [2:0]        bitc_q;
  logic [7:0]        bytec_q;
  logic              count_up_q;
  logic              bg_flag_q;
  logic [7:0]        delay_q;

  // Pipeline
  logic               s1_valid_q;
  s1_t                s1_q;
  s1_t                s1_d;
  logic               out_valid_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_fg_q;

  logic        advance;
  logic        in_acc;
  logic        pix_acc;
  logic        line_acc;
  logic        load_acc;
  func_e       func;

  // Pixel-side combinational values
  logic              cu_now;
  logic              bg_now;
  logic              road_on;
  logic [2:0]        bit_sel;
  logic [ROW_W-1:0]  rd_row;
  logic [COL_W-1:0]  rd_col;
  logic              rd_row_ok;
  logic              ld_row_ok;

  // RAM port
  logic                  ram_en;
  logic                  ram_we;
  logic [GFX_ADDR_W-1:0] ram_addr;
  logic [GFX_W-1:0]      ram_rdata;
  logic [ROW_W+COL_W-1:0] lin_addr;

  // Color stage
  logic [GFX_W-1:0]   md;
  logic [GFX_W-1:0]   md_pix;
  logic               pix_bit;
  logic [COLOR_W-1:0] color;

  // Handshake: the pipe moves whenever stage 1 is empty or can hand off to the output.
  assign advance     = !s1_valid_q || !out_valid_q || out_o.ready;
  assign in_i.ready  = advance;
  assign in_acc      = in_i.valid && advance;
  assign func        = func_e'(in_i.func);
  assign load_acc    = in_acc && (func == FUNC_LOAD);
  assign line_acc    = in_acc && (func == FUNC_LINE);
  assign pix_acc     = in_acc && (func == FUNC_PIXEL);

  // Pre-step updates of the direction and background flags.
  always_comb begin
    cu_now = count_up_q;
    if (bytec_q == 8'hff) begin
      cu_now = 1'b0;
    end
    if (!ctrl_q[8]) begin
      cu_now = 1'b1;
    end
    bg_now = bg_flag_q;
    if (!variant_q && !ctrl_q[9]) begin
      bg_now = 1'b1;
    end
  end

  // Road data shows only in the top quarter of the byte range, unless disabled.
  assign road_on   = (!variant_q || !ctrl_q[9]) && (bytec_q[7:6] == 2'b11);
  assign bit_sel   = delay_q[0] ? bitc_q : (bitc_q ^ 3'd7);
  assign rd_row    = ctrl_q[7:0];
  assign rd_col    = {bytec_q[5:0], bit_sel};
  assign rd_row_ok = ({1'b0, rd_row} < 9'(GRAPHICS_ROWS));
  assign ld_row_ok = ({1'b0, in_i.graphics_row} < 9'(GRAPHICS_ROWS));

  // One RAM access per cycle: a load writes, a pixel reads. A read issued after a
  // write sees it, so no forwarding is needed.
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    lin_addr = {rd_row, rd_col};
    if (load_acc && ld_row_ok) begin
      ram_en   = 1'b1;
      ram_we   = 1'b1;
      lin_addr = {in_i.graphics_row, in_i.graphics_column};
    end else if (pix_acc && road_on && rd_row_ok) begin
      ram_en   = 1'b1;
    end
  end
  assign ram_addr = lin_addr[GFX_ADDR_W-1:0];

  rsp_ram #(
    .WIDTH (GFX_W),
    .DEPTH (GFX_DEPTH)
  ) u_gfx_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.graphics_value),
    .rdata_o (ram_rdata)
  );

  // Capture what the color stage needs from the line state at accept time.
  always_comb begin
    s1_d.bg_fill    = bg_now;
    s1_d.md_read    = road_on && rd_row_ok;
    s1_d.select     = delay_q[3];
    s1_d.bg_color   = delay_q[3] ? bgc_q[5:0] : bgc_q[13:8];
    s1_d.pix_colors = pixc_q;
    s1_d.fg         = (ctrl_q[11:10] != 2'b00);
  end

  // Color stage: a missing read or a disabled row reads as the background value.
  assign md      = s1_q.md_read ? ram_rdata : MD_BACKGROUND;
  assign md_pix  = (s1_q.pix_colors[7] && (md == MD_BACKGROUND)) ? 2'd0 : md;
  assign pix_bit = s1_q.pix_colors[{md_pix, s1_q.select}];

  always_comb begin
    if (s1_q.bg_fill && (md == MD_BACKGROUND)) begin
      color = {10'd0, s1_q.bg_color} | bg_base_q;
    end else begin
      color = {12'd0, s1_q.select, md_pix, pix_bit} | pix_base_q;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q  <= 1'b0;
      pix_base_q <= '0;
      bg_base_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ROAD_VARIANT: variant_q  <= cfg_data_i[0];
        REG_PIXEL_BASE:   pix_base_q <= cfg_data_i;
        REG_BG_BASE:      bg_base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line state: preset on line start, step on each pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q     <= '0;
      bgc_q      <= '0;
      pixc_q     <= '0;
      bitc_q     <= '0;
      bytec_q    <= '0;
      count_up_q <= 1'b0;
      bg_flag_q  <= 1'b1;
      delay_q    <= '0;
    end else if (line_acc) begin
      ctrl_q     <= in_i.line_control;
      bgc_q      <= in_i.line_background_colors;
      pixc_q     <= in_i.line_pixel_colors;
      bitc_q     <= in_i.line_scroll[2:0];
      bytec_q    <= in_i.line_scroll[10:3];
      count_up_q <= in_i.line_scroll[11];
      bg_flag_q  <= 1'b1;
      delay_q    <= '0;
    end else if (pix_acc) begin
      bitc_q     <= bitc_q + 3'd1;
      if (bitc_q == 3'd7) begin
        bytec_q <= cu_now ? bytec_q + 8'd1 : bytec_q - 8'd1;
      end
      count_up_q <= cu_now;
      bg_flag_q  <= !(!cu_now && delay_q[7]);
      delay_q    <= {delay_q[6:0], cu_now};
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_q <= pix_acc;
      end
      if (!out_valid_q || out_o.ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && (!out_valid_q || out_o.ready)) begin
      out_color_q <= color;
      out_fg_q    <= s1_q.fg;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.pixel_color        = out_color_q;
  assign out_o.is_foreground_line = out_fg_q;

  // A line start presets the background flag and clears the delay shifter.
  a_line_preset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_acc |=> (bg_flag_q && (delay_q == 8'd0)))
    else $error("line start did not preset flag and shifter");

  // Every accepted pixel enters stage 1.
  a_pix_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> s1_valid_q)
    else $error("accepted pixel lost before stage 1");

  // The bit counter steps once per pixel.
  a_bit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> (bitc_q == $past(bitc_q) + 3'd1))
    else $error("bit counter did not step");

  // Output valid rises only when stage 1 held a pixel.
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a pixel in stage 1");

  // Stage 1 never stalls while the output is free.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |-> in_i.ready)
    else $error("pipe stalled with an empty output register");

endmodule

// ===== hw/rtl/rsp_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Standalone; read data holds while the port is not enabled for a read.
`timescale 1ns / 1ps

module rsp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/road_scanline_pixel_generator_test.sv =====
// Testbench for road_scanline_pixel_generator: streams load, line-start and pixel items
// through the valid/ready channels and checks every pixel against a built-in predictor.
// Depends on rsp_pkg, rsp_in_if, rsp_out_if and the block itself.
`timescale 1ns / 1ps

module road_scanline_pixel_generator_test;
  import rsp_pkg::*;

  // Code 3 on the func field has no meaning; the block must swallow it silently
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Rows that line starts draw their graphics from, so loaded pixels get reused
  localparam int LINE_ROW_COUNT = 6;
  localparam int LINE_ROW_IDX_W = $clog2(LINE_ROW_COUNT);

  // A pixel's result is registered in stage 1 and the output register; leave some slack
  // before touching registers
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [GFX_W-1:0]    value;
    logic [CTRL_W-1:0]   ctrl;
    logic [SCROLL_W-1:0] scroll;
    logic [BGC_W-1:0]    bgc;
    logic [PIXC_W-1:0]   pixc;
  } road_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               fg;
  } pixel_t;

  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rsp_in_if  in_if ();
  rsp_out_if out_if ();

  road_scanline_pixel_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the graphics store, registers and line
  // state, advanced once per accepted item.
  // ---------------------------------------------------------------------------
  logic [GFX_W-1:0]    gfx_mem     [GFX_DEPTH];
  bit                  gfx_written [GFX_DEPTH];
  logic                variant   = 1'b0;
  logic [COLOR_W-1:0]  pix_base  = '0;
  logic [COLOR_W-1:0]  bg_base   = '0;
  logic [CTRL_W-1:0]   line_ctrl = '0;
  logic [BGC_W-1:0]    line_bgc  = '0;
  logic [PIXC_W-1:0]   line_pixc = '0;
  logic [2:0]          bit_cnt   = '0;
  logic [7:0]          byte_cnt  = '0;
  logic                up_flag   = 1'b0;
  logic                bg_flag   = 1'b1;
  logic [7:0]          delay_sr  = '0;

  pixel_t expected_pixels [$];

  logic [ROW_W-1:0] line_rows [LINE_ROW_COUNT];

  // Sender and receiver pacing
  int unsigned burst_left      = 0;
  bit          gapless         = 1'b0;
  int unsigned hold_cycles_req = 0;

  // Bookkeeping
  int unsigned n_items    = 0;
  int unsigned n_loads    = 0;
  int unsigned n_lines    = 0;
  int unsigned n_pixels   = 0;
  int unsigned n_ignored  = 0;
  int unsigned n_checked  = 0;
  int unsigned n_settings = 0;
  int unsigned n_holds    = 0;
  int unsigned error_count = 0;

  // Report the first few mismatches in full, count the rest.
  task automatic note_error(string what, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  // Graphics address the next pixel reads, and whether it reads one at all.
  // Road data is fetched only in the top quarter of the byte range and only
  // while the line does not disable it.
  function automatic bit gfx_read_addr(output logic [GFX_ADDR_W-1:0] addr);
    logic [2:0] bsel;
    bsel = delay_sr[0] ? bit_cnt : ~bit_cnt;
    addr = {line_ctrl[7:0], byte_cnt[5:0], bsel};
    return (!variant || !line_ctrl[9]) && (byte_cnt[7:6] == 2'b11);
  endfunction

  // Color and layer flag of one pixel, then clock the line counters.
  function automatic void predict_pixel_color(output logic [COLOR_W-1:0] color,
                                              output logic fg);
    logic                  advance_byte;
    logic [GFX_W-1:0]      md;
    logic                  sel;
    logic [GFX_ADDR_W-1:0] addr;
    advance_byte = (bit_cnt == 3'd7);
    md = MD_BACKGROUND;
    if (byte_cnt == 8'hff) up_flag = 1'b0;
    if (!line_ctrl[8]) up_flag = 1'b1;
    if (!variant && !line_ctrl[9]) bg_flag = 1'b1;
    if (gfx_read_addr(addr)) md = gfx_mem[addr];
    sel = delay_sr[3];
    if (bg_flag && md == MD_BACKGROUND) begin
      color = bg_base | {10'd0, (sel ? line_bgc[5:0] : line_bgc[13:8])};
    end else begin
      // bit 7 of the pixel colors turns value 3 into value 0
      if (line_pixc[7] && md == MD_BACKGROUND) md = '0;
      color = pix_base | {12'd0, sel, md, line_pixc[{md, sel}]};
    end
    fg = |line_ctrl[11:10];
    bit_cnt = bit_cnt + 3'd1;
    if (advance_byte) byte_cnt = up_flag ? byte_cnt + 8'd1 : byte_cnt - 8'd1;
    bg_flag = !(!up_flag && delay_sr[7]);
    delay_sr = {delay_sr[6:0], up_flag};
  endfunction

  // Advance the predictor by one accepted item.
  function automatic void track_item(road_item_t it);
    pixel_t px;
    case (it.func)
      FUNC_LOAD: begin
        gfx_mem[{it.row, it.col}]     = it.value;
        gfx_written[{it.row, it.col}] = 1'b1;
        n_loads++;
      end
      FUNC_LINE: begin
        line_ctrl = it.ctrl;
        line_bgc  = it.bgc;
        line_pixc = it.pixc;
        bit_cnt   = it.scroll[2:0];
        byte_cnt  = it.scroll[10:3];
        up_flag   = it.scroll[11];
        bg_flag   = 1'b1;
        delay_sr  = '0;
        n_lines++;
      end
      FUNC_PIXEL: begin
        predict_pixel_color(px.color, px.fg);
        expected_pixels.push_back(px);
        n_pixels++;
      end
      default: begin
        n_ignored++;
      end
    endcase
    if (it.func != FUNC_UNUSED) n_items++;
  endfunction

  // ---------------------------------------------------------------------------
  // Sending side. Called at a rising edge; returns at the edge that accepted
  // the item, with valid still high so a following item streams on.
  // ---------------------------------------------------------------------------
  task automatic send_item(road_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gapless || $urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    in_if.valid                  <= 1'b1;
    in_if.func                   <= it.func;
    in_if.graphics_row           <= it.row;
    in_if.graphics_column        <= it.col;
    in_if.graphics_value         <= it.value;
    in_if.line_control           <= it.ctrl;
    in_if.line_scroll            <= it.scroll;
    in_if.line_background_colors <= it.bgc;
    in_if.line_pixel_colors      <= it.pixc;
    do
      @(posedge clk_i);
    while (!in_if.ready);
    track_item(it);
  endtask

  // Fill every field with noise; callers override what their func uses.
  function automatic road_item_t random_fields();
    road_item_t it;
    it.func   = FUNC_UNUSED;
    it.row    = ROW_W'($urandom);
    it.col    = COL_W'($urandom);
    it.value  = GFX_W'($urandom);
    it.ctrl   = CTRL_W'($urandom);
    it.scroll = SCROLL_W'($urandom);
    it.bgc    = BGC_W'($urandom);
    it.pixc   = PIXC_W'($urandom);
    return it;
  endfunction

  // One of the rows that line starts draw from.
  function automatic logic [ROW_W-1:0] pick_line_row();
    return line_rows[LINE_ROW_IDX_W'($urandom_range(LINE_ROW_COUNT - 1))];
  endfunction

  task automatic send_load(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [GFX_W-1:0] value);
    road_item_t it;
    it = random_fields();
    it.func  = FUNC_LOAD;
    it.row   = row;
    it.col   = col;
    it.value = value;
    send_item(it);
  endtask

  task automatic send_line(logic [CTRL_W-1:0] ctrl, logic [SCROLL_W-1:0] scroll,
                           logic [BGC_W-1:0] bgc, logic [PIXC_W-1:0] pixc);
    road_item_t it;
    it = random_fields();
    it.func   = FUNC_LINE;
    it.ctrl   = ctrl;
    it.scroll = scroll;
    it.bgc    = bgc;
    it.pixc   = pixc;
    send_item(it);
  endtask

  // Load the entry the next pixel will read if it still holds nothing, so
  // that no pixel ever reads an undefined graphics entry.
  task automatic send_pixel();
    road_item_t            it;
    logic [GFX_ADDR_W-1:0] addr;
    if (gfx_read_addr(addr) && !gfx_written[addr])
      send_load(addr[GFX_ADDR_W-1:COL_W], addr[COL_W-1:0], GFX_W'($urandom));
    it = random_fields();
    it.func = FUNC_PIXEL;
    send_item(it);
  endtask

  task automatic send_noise();
    send_item(random_fields());
  endtask

  function automatic logic [CTRL_W-1:0] random_control();
    logic [CTRL_W-1:0] c;
    c = CTRL_W'($urandom);
    c[ROW_W-1:0] = pick_line_row();
    return c;
  endfunction

  // Bias the start byte toward the road-data window and the top of the range,
  // where the count turns around and the background flag drops.
  function automatic logic [SCROLL_W-1:0] random_scroll();
    logic [SCROLL_W-1:0] s;
    int unsigned         pick;
    s = SCROLL_W'($urandom);
    pick = $urandom_range(9);
    if (pick < 4) s[10:3] = 8'($urandom_range(8'hff, 8'hf0));
    else if (pick < 7) s[10:3] = 8'($urandom_range(8'hff, 8'hc0));
    return s;
  endfunction

  // Drop valid and let every pixel drain before registers are touched.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; the predictor takes the value at the same edge.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_ROAD_VARIANT: variant  = data[0];
      REG_PIXEL_BASE:   pix_base = data;
      REG_BG_BASE:      bg_base  = data;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pixels with no line started yet run on the reset line state.
  task automatic test_pixels_after_reset();
    repeat (2) send_pixel();
  endtask

  // Store corners, the ignored func code, and the counter turn-arounds.
  task automatic test_field_extremes();
    send_load(8'hff, 9'h1ff, 2'd3);
    send_load(8'h00, 9'h000, 2'd0);
    send_load(8'hff, 9'h000, 2'd2);
    send_noise();
    // all-ones line on the top row: counting up from byte 0xff turns the count down
    send_line(12'hfff, 12'hfff, 16'hffff, 8'hff);
    repeat (3) send_pixel();
    // row 0 with the direction forced up: byte 0xff wraps to 0, value 3 clamps
    send_line(12'h000, 12'h7ff, 16'h0000, 8'h80);
    repeat (3) send_pixel();
    // counting down from byte 0 wraps to 0xff on a foreground line
    send_line(12'h500, 12'h007, 16'h3f3f, 8'h55);
    repeat (3) send_pixel();
  endtask

  // Random lines: mostly well-formed line-then-pixels runs, with stray loads,
  // ignored codes and lines restarted mid-way mixed in.
  task automatic run_random_lines(int unsigned quota);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    stop_at = n_items + quota;
    while (n_items < stop_at) begin
      send_line(random_control(), random_scroll(), BGC_W'($urandom), PIXC_W'($urandom));
      pick = $urandom_range(19);
      if (pick == 0) len = $urandom_range(600, 300);
      else if (pick < 6) len = $urandom_range(160, 49);
      else len = $urandom_range(48, 4);
      // cut the line short once the quota is reached
      for (int unsigned k = 0; k < len && n_items < stop_at; k++) begin
        case ($urandom_range(24))
          0: begin
            if ($urandom_range(1) == 0)
              send_load(pick_line_row(), COL_W'($urandom), GFX_W'($urandom));
            else
              send_load(ROW_W'($urandom), COL_W'($urandom), GFX_W'($urandom));
          end
          1: send_noise();
          2: send_line(random_control(), random_scroll(), BGC_W'($urandom),
                       PIXC_W'($urandom));
          default: send_pixel();
        endcase
      end
    end
  endtask

  // Walk through register settings, extremes first, with random traffic in each.
  task automatic test_config_settings();
    logic                  v;
    logic [CFG_DATA_W-1:0] vdata;
    logic [CFG_DATA_W-1:0] pb;
    logic [CFG_DATA_W-1:0] bb;
    for (int i = 0; i < 6; i++) begin
      case (i)
        0: begin v = 1'b0; pb = 16'h0000; bb = 16'h0000; end
        1: begin v = 1'b1; pb = 16'hffff; bb = 16'hffff; end
        2: begin v = 1'b0; pb = 16'hffff; bb = 16'h0000; end
        3: begin v = 1'b1; pb = 16'h0000; bb = 16'hffff; end
        default: begin
          v  = 1'($urandom);
          pb = CFG_DATA_W'($urandom);
          bb = CFG_DATA_W'($urandom);
        end
      endcase
      // only bit 0 of the variant register counts; stir the rest on random phases
      vdata = (i < 4) ? {15'd0, v} : {15'($urandom), v};
      wait_drained();
      write_reg(REG_ROAD_VARIANT, vdata);
      write_reg(REG_PIXEL_BASE, pb);
      write_reg(REG_BG_BASE, bb);
      cfg_we_i <= 1'b0;
      n_settings++;
      run_random_lines(280);
    end
  endtask

  // Hold the receiver off for a long stretch while pixels keep coming, so the
  // block fills up and stalls its input.
  task automatic test_output_hold_off();
    gapless = 1'b1;
    hold_cycles_req = 400;
    send_line(random_control(), random_scroll(), BGC_W'($urandom), PIXC_W'($urandom));
    repeat (120) send_pixel();
    gapless = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a random pattern that is redrawn whenever its run ends,
  // with long hold-offs on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode = RX_STREAM;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_cycles_req != 0) begin
        hold_left = hold_cycles_req;
        hold_cycles_req = 0;
        n_holds++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(RX_PERIODIC));
          mode_left = $urandom_range(120, 20);
        end
        mode_left--;
        case (mode)
          RX_STREAM: out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= ($urandom_range(1) == 0);
          RX_SPARSE: out_if.ready <= ($urandom_range(3) == 0);
          default:   out_if.ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each accepted pixel against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t want;
    if (out_if.valid && out_if.ready) begin
      n_checked++;
      if (expected_pixels.size() == 0) begin
        note_error("unexpected pixel", '0, out_if.pixel_color);
      end else begin
        want = expected_pixels.pop_front();
        if (out_if.pixel_color !== want.color)
          note_error("pixel_color", want.color, out_if.pixel_color);
        if (out_if.is_foreground_line !== want.fg)
          note_error("is_foreground_line", {15'd0, want.fg}, {15'd0, out_if.is_foreground_line});
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d pixels still outstanding", expected_pixels.size());
    $display("road_scanline_pixel_generator_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    // hold every input at a known value from time zero
    rst_ni                       <= 1'b0;
    cfg_we_i                     <= 1'b0;
    cfg_idx_i                    <= REG_ROAD_VARIANT;
    cfg_data_i                   <= '0;
    in_if.valid                  <= 1'b0;
    in_if.func                   <= FUNC_LOAD;
    in_if.graphics_row           <= '0;
    in_if.graphics_column        <= '0;
    in_if.graphics_value         <= '0;
    in_if.line_control           <= '0;
    in_if.line_scroll            <= '0;
    in_if.line_background_colors <= '0;
    in_if.line_pixel_colors      <= '0;

    // keep both ends of the row range in the pool, draw the rest at random
    line_rows[0] = '0;
    line_rows[1] = '1;
    for (int i = 2; i < LINE_ROW_COUNT; i++) line_rows[LINE_ROW_IDX_W'(i)] = ROW_W'($urandom);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pixels_after_reset();
    test_field_extremes();
    test_config_settings();
    test_output_hold_off();

    // drain, then give the pipeline time to show any stray pixel
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0)
      note_error("missing pixels", '0, COLOR_W'(expected_pixels.size()));

    $display("covered %0d items: %0d loads, %0d line starts, %0d pixels (+%0d ignored codes)",
             n_items, n_loads, n_lines, n_pixels, n_ignored);
    $display("%0d pixels checked over %0d register settings and %0d long output hold-offs",
             n_checked, n_settings, n_holds);
    if (error_count == 0) begin
      $display("road_scanline_pixel_generator_test: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("road_scanline_pixel_generator_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== road_scanline_pixel_generator.f =====
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_in_if.sv
hw/rtl/rsp_out_if.sv
hw/rtl/rsp_ram.sv
hw/rtl/road_scanline_pixel_generator.sv
tb/road_scanline_pixel_generator_test.sv
